[rtl/msgp_pkg.sv]
// Shared types and constants for the message packetizer.
// Depends on nothing; every other file in the block imports it.
package msgp_pkg;

    localparam int AddrW    = 40;
    localparam int FlagW    = 16;
    localparam int LimW     = 16;
    localparam int LenW     = 24;
    localparam int ByteW    = 8;
    localparam int CfgDataW = 40;
    localparam int CfgIdxW  = 3;
    localparam int TotalW   = 17;
    localparam int SumW     = 42;
    localparam int IdxW     = 5;

    // Header layout: 24 header bytes, then the payload word at position 24
    localparam logic [IdxW-1:0]  LastIdx  = 5'd24;
    localparam logic [ByteW-1:0] SrcPort  = 8'h20;
    localparam logic [ByteW-1:0] DstPort  = 8'h40;
    localparam logic [TotalW-1:0] HdrLen  = 17'd24;

    // Configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        REG_SRC_ADDR  = 3'd0,
        REG_DST_ADDR  = 3'd1,
        REG_FLAGS     = 3'd2,
        REG_PAY_LIMIT = 3'd3,
        REG_PKT_LIMIT = 3'd4,
        REG_MSG_LEN   = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [AddrW-1:0] source_addr;
        logic [AddrW-1:0] dst_addr;
        logic [FlagW-1:0] flags;
        logic [LimW-1:0]  pay_limit;
        logic [LimW-1:0]  pkt_limit;
        logic [LenW-1:0]  msg_len;
    } t_cfg;

    // One accepted word on its way to the serializer
    typedef struct packed {
        logic [ByteW-1:0]  data;
        logic [LimW-1:0]   num;
        logic [LenW-1:0]   frag;
        logic [TotalW-1:0] total;
        logic              hdr;
        logic              eop;
        logic              eom;
    } t_job;

endpackage

[rtl/msgp_if.sv]
// Handshake channels of the message packetizer: message input, packet
// output and configuration writes. Depends on msgp_pkg.
interface msgp_in_if import msgp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ByteW-1:0] message_byte;
    modport source (output valid, output message_byte, input ready);
    modport sink   (input valid, input message_byte, output ready);
endinterface

interface msgp_out_if import msgp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ByteW-1:0] packet_byte;
    logic [LimW-1:0]  packet_number;
    logic             end_of_packet;
    logic             end_of_message;
    modport source (output valid, output packet_byte, output packet_number,
                    output end_of_packet, output end_of_message, input ready);
    modport sink   (input valid, input packet_byte, input packet_number,
                    input end_of_packet, input end_of_message, output ready);
endinterface

interface msgp_cfg_if import msgp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/msgp_cfg.sv]
// Configuration register file of the message packetizer.
// Depends on msgp_pkg and msgp_cfg_if.
module msgp_cfg import msgp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    msgp_cfg_if.sink    i_cfg,
    output t_cfg        o_cfg,
    output logic        o_msg_clear
);

    t_cfg r_cfg;
    logic wr;

    assign i_cfg.ready = 1'b1;
    assign wr          = i_cfg.valid && i_cfg.ready;
    assign o_cfg       = r_cfg;

    // Pulse a message restart when the length register is written
    assign o_msg_clear = wr && (i_cfg.index == REG_MSG_LEN);

    // Decode the write word into its register, cut to width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.source_addr <= '0;
            r_cfg.dst_addr    <= '0;
            r_cfg.flags       <= '0;
            r_cfg.pay_limit   <= 16'd1;
            r_cfg.pkt_limit   <= '0;
            r_cfg.msg_len     <= '0;
        end else if (wr) begin
            unique case (t_reg_idx'(i_cfg.index))
                REG_SRC_ADDR:  r_cfg.source_addr <= i_cfg.data[AddrW-1:0];
                REG_DST_ADDR:  r_cfg.dst_addr    <= i_cfg.data[AddrW-1:0];
                REG_FLAGS:     r_cfg.flags       <= i_cfg.data[FlagW-1:0];
                REG_PAY_LIMIT: r_cfg.pay_limit   <= i_cfg.data[LimW-1:0];
                REG_PKT_LIMIT: r_cfg.pkt_limit   <= i_cfg.data[LimW-1:0];
                REG_MSG_LEN:   r_cfg.msg_len     <= i_cfg.data[LenW-1:0];
                default: ;
            endcase
        end
    end

endmodule

[rtl/msgp_ctrl.sv]
// Message tracking for the packetizer: counts taken words, decides packet
// boundaries and drops, and hands a job to the serializer. Depends on msgp_pkg, msgp_in_if.
module msgp_ctrl import msgp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_msg_clear,
    input  logic        i_slot_free,
    msgp_in_if.sink     i_msg,
    output logic        o_job_load,
    output t_job        o_job
);

    logic [LenW-1:0] r_bytes_taken, r_frag;
    logic [LimW-1:0] r_pkts, r_pos;

    logic            take, active, start, drop, eop, eom;
    logic [LimW-1:0] limit, plen, pos1, pkts1;
    logic [LenW-1:0] remaining, taken1;

    assign i_msg.ready = i_slot_free;
    assign take        = i_msg.valid && i_msg.ready;

    // Work out the packet geometry for the word at the input
    always_comb begin
        limit     = (i_cfg.pay_limit == '0) ? 16'd1 : i_cfg.pay_limit;
        active    = r_bytes_taken < i_cfg.msg_len;
        remaining = i_cfg.msg_len - r_frag;
        plen      = (remaining < {8'd0, limit}) ? remaining[LimW-1:0] : limit;
        start     = (r_pos == '0);
        drop      = start && (r_pkts >= i_cfg.pkt_limit);
        taken1    = r_bytes_taken + 24'd1;
        pos1      = r_pos + 16'd1;
        pkts1     = r_pkts + 16'd1;
        eop       = pos1 >= plen;
        eom       = eop && ((taken1 >= i_cfg.msg_len) || (pkts1 >= i_cfg.pkt_limit));
    end

    // Hand over a job for every word that produces output
    assign o_job_load = take && active && !drop;
    assign o_job.data  = i_msg.message_byte;
    assign o_job.num   = r_pkts;
    assign o_job.frag  = r_frag;
    assign o_job.total = HdrLen + {1'b0, plen};
    assign o_job.hdr   = start;
    assign o_job.eop   = eop;
    assign o_job.eom   = eom;

    // Advance the message counters; a length write restarts the message
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_msg_clear) begin
            r_bytes_taken <= '0;
            r_frag        <= '0;
            r_pkts        <= '0;
            r_pos         <= '0;
        end else if (take && active) begin
            r_bytes_taken <= taken1;
            if (!drop) begin
                if (eop) begin
                    r_frag <= taken1;
                    r_pos  <= '0;
                    r_pkts <= pkts1;
                end else begin
                    r_pos  <= pos1;
                end
            end
        end
    end

    a_taken_in_msg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes_taken <= i_cfg.msg_len)
        else $error("taken count ran past the message length");

    a_frag_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frag <= r_bytes_taken)
        else $error("fragment offset ahead of taken count");

    a_clear_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_msg_clear |=> (r_bytes_taken == '0) && (r_pos == '0))
        else $error("length write did not restart the message");

endmodule

[rtl/msgp_emit.sv]
// Packet serializer: holds one job, walks the 24 header words (first word of a
// packet only) and the payload word into the output register. Depends on msgp_pkg, msgp_out_if.
module msgp_emit import msgp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_job_load,
    input  t_job        i_job,
    output logic        o_slot_free,
    msgp_out_if.source  o_pkt
);

    logic            r_job_valid;
    t_job            r_job;
    logic [IdxW-1:0] r_idx;
    logic [SumW-1:0] r_sum;

    logic             r_out_valid;
    logic [ByteW-1:0] r_out_byte;
    logic [LimW-1:0]  r_out_num;
    logic             r_out_eop, r_out_eom;

    logic             out_free, step, last, job_done;
    logic [SumW-1:0]  n_sum;
    logic [32:0]      fold_a;
    logic [31:0]      fold_b, chk;
    logic [LenW-1:0]  total24;
    logic [ByteW-1:0] n_byte;

    assign out_free    = !r_out_valid || o_pkt.ready;
    assign step        = r_job_valid && out_free;
    assign last        = (r_idx == LastIdx);
    assign job_done    = step && last;
    assign o_slot_free = !r_job_valid || job_done;

    // Raw header sum, registered; it settles after a job loads, long before use
    assign n_sum = {2'd0, i_cfg.source_addr} + {2'd0, i_cfg.dst_addr}
                 + {34'd0, SrcPort} + {34'd0, DstPort}
                 + {18'd0, r_job.frag} + {26'd0, i_cfg.flags}
                 + {25'd0, r_job.total};

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
    end

    // Reduce modulo 2^32-1 by end-around folding
    always_comb begin
        fold_a = {1'b0, r_sum[31:0]} + {23'd0, r_sum[SumW-1:32]};
        fold_b = fold_a[31:0] + {31'd0, fold_a[32]};
        chk    = (fold_b == 32'hFFFF_FFFF) ? 32'd0 : fold_b;
    end

    assign total24 = {7'd0, r_job.total};

    // Select the header word, or the payload word, at the current position
    always_comb begin
        case (r_idx)
            5'd0:    n_byte = i_cfg.source_addr[39:32];
            5'd1:    n_byte = i_cfg.source_addr[31:24];
            5'd2:    n_byte = i_cfg.source_addr[23:16];
            5'd3:    n_byte = i_cfg.source_addr[15:8];
            5'd4:    n_byte = i_cfg.source_addr[7:0];
            5'd5:    n_byte = i_cfg.dst_addr[39:32];
            5'd6:    n_byte = i_cfg.dst_addr[31:24];
            5'd7:    n_byte = i_cfg.dst_addr[23:16];
            5'd8:    n_byte = i_cfg.dst_addr[15:8];
            5'd9:    n_byte = i_cfg.dst_addr[7:0];
            5'd10:   n_byte = SrcPort;
            5'd11:   n_byte = DstPort;
            5'd12:   n_byte = r_job.frag[23:16];
            5'd13:   n_byte = r_job.frag[15:8];
            5'd14:   n_byte = r_job.frag[7:0];
            5'd15:   n_byte = i_cfg.flags[15:8];
            5'd16:   n_byte = i_cfg.flags[7:0];
            5'd17:   n_byte = total24[23:16];
            5'd18:   n_byte = total24[15:8];
            5'd19:   n_byte = total24[7:0];
            5'd20:   n_byte = chk[31:24];
            5'd21:   n_byte = chk[23:16];
            5'd22:   n_byte = chk[15:8];
            5'd23:   n_byte = chk[7:0];
            default: n_byte = r_job.data;
        endcase
    end

    // Hold the job and advance through its words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_idx       <= '0;
        end else if (i_job_load) begin
            r_job_valid <= 1'b1;
            r_idx       <= i_job.hdr ? '0 : LastIdx;
        end else if (job_done) begin
            r_job_valid <= 1'b0;
        end else if (step) begin
            r_idx       <= r_idx + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_job_load) begin
            r_job <= i_job;
        end
    end

    // Output register: load on a step, drop when the word is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_pkt.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_byte <= n_byte;
            r_out_num  <= r_job.num;
            r_out_eop  <= last && r_job.eop;
            r_out_eom  <= last && r_job.eom;
        end
    end

    assign o_pkt.valid          = r_out_valid;
    assign o_pkt.packet_byte    = r_out_byte;
    assign o_pkt.packet_number  = r_out_num;
    assign o_pkt.end_of_packet  = r_out_eop;
    assign o_pkt.end_of_message = r_out_eom;

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid |-> r_idx <= LastIdx)
        else $error("word position past the payload word");

    a_eom_on_eop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_eom) |-> r_out_eop)
        else $error("end of message without end of packet");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job_load |-> o_slot_free)
        else $error("job loaded over a busy slot");

endmodule

[rtl/message_packetizer.sv]
// Message packetizer: a taken input word is held as a job, then moved to the
// output register. Payload words flow at one per cycle while the output is not
// stalled; a packet's first word yields 24 header words plus itself, holding
// the input while the serializer walks the header. Synchronous active-low
// reset clears message counters, loads payload_limit 1, other config regs 0.
module message_packetizer import msgp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    msgp_cfg_if.sink    i_cfg,
    msgp_in_if.sink     i_msg,
    msgp_out_if.source  o_pkt
);

    t_cfg cfg;
    logic msg_clear;
    logic slot_free;
    logic job_load;
    t_job job;

    msgp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (i_cfg),
        .o_cfg       (cfg),
        .o_msg_clear (msg_clear)
    );

    msgp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_msg_clear (msg_clear),
        .i_slot_free (slot_free),
        .i_msg       (i_msg),
        .o_job_load  (job_load),
        .o_job       (job)
    );

    msgp_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_job_load  (job_load),
        .i_job       (job),
        .o_slot_free (slot_free),
        .o_pkt       (o_pkt)
    );

endmodule
